/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the offset unit rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/ptro_pkg.sv */
// ----------------------------------------------------------------------------
// ptro_pkg
// types, constants and calendar helpers of the tz rule offset unit
// ----------------------------------------------------------------------------
package ptro_pkg;

  localparam logic [11:0] YEAR_LOW  = 12'd1900;
  localparam logic [8:0]  YOFF_MAX  = 9'd300;
  localparam int          YOFF_W    = 9;
  localparam int          SEARCH_STEPS = 9;

  // rule date form codes, codes two and three act as the zero-based form
  localparam logic [1:0] FORM_MWD  = 2'd0;
  localparam logic [1:0] FORM_JDAY = 2'd1;

  typedef enum logic [2:0] {
    REG_STD_OFF    = 3'd0,
    REG_DST_OFF    = 3'd1,
    REG_DST_EN     = 3'd2,
    REG_START_DATE = 3'd3,
    REG_START_TIME = 3'd4,
    REG_END_DATE   = 3'd5,
    REG_END_TIME   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                valid;
    logic signed [34:0]  secs;
    logic [YOFF_W-1:0]   yoff;
  } year_req_t;

  // days from 1970-01-01 to jan 1 of year yr, yr in 1900..2200
  function automatic logic signed [17:0] year_days(input logic [11:0] yr);
    logic [11:0]        n;
    logic [4:0]         q100;
    logic [2:0]         q400;
    logic signed [19:0] acc;
    n = yr - 12'd1;
    if (n < 12'd1900) q100 = 5'd18;
    else if (n < 12'd2000) q100 = 5'd19;
    else if (n < 12'd2100) q100 = 5'd20;
    else q100 = 5'd21;
    q400 = (n < 12'd2000) ? 3'd4 : 3'd5;
    acc = ($signed({8'd0, yr}) - 20'sd1970) * 20'sd365;
    acc = acc + $signed({10'd0, n[11:2]}) - $signed({15'd0, q100})
        + $signed({17'd0, q400}) - 20'sd477;
    return acc[17:0];
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    unique case (mon)
      4'd2:                     d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* rtl/posix_tz_rule_offset_unit.sv */
// ----------------------------------------------------------------------------
// posix_tz_rule_offset_unit
// utc offset and daylight flag of a timestamp under a posix tz rule
// ----------------------------------------------------------------------------
// pipeline: 9 search stages, 4 rule stages and 1 decision/output stage; one request
// per cycle is accepted while no finished result is stalled
// the whole pipeline advances together and holds while a result is stalled
// reset: synchronous active-low rst_n clears all valid bits and loads the
// register defaults (std 0, dst 3600, daylight off, rule times 7200)
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module posix_tz_rule_offset_unit (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [34:0] in_unix_seconds,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_utc_offset_seconds,
  output logic               out_in_dst,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // register file
  logic signed [17:0] std_off_r, dst_off_r;
  logic               dst_en_r;
  logic [20:0]        start_date_r, end_date_r;
  logic signed [20:0] start_time_r, end_time_r;
  logic               wr_en;
  ptro_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = ptro_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_off_r    <= 18'sd0;
      dst_off_r    <= 18'sd3600;
      dst_en_r     <= 1'b0;
      start_date_r <= 21'd0;
      start_time_r <= 21'sd7200;
      end_date_r   <= 21'd0;
      end_time_r   <= 21'sd7200;
    end else if (wr_en) begin
      unique case (reg_idx)
        ptro_pkg::REG_STD_OFF:    std_off_r    <= pwdata[17:0];
        ptro_pkg::REG_DST_OFF:    dst_off_r    <= pwdata[17:0];
        ptro_pkg::REG_DST_EN:     dst_en_r     <= pwdata[0];
        ptro_pkg::REG_START_DATE: start_date_r <= pwdata[20:0];
        ptro_pkg::REG_START_TIME: start_time_r <= pwdata[20:0];
        ptro_pkg::REG_END_DATE:   end_date_r   <= pwdata[20:0];
        ptro_pkg::REG_END_TIME:   end_time_r   <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ptro_pkg::REG_STD_OFF:    prdata = {14'd0, std_off_r};
      ptro_pkg::REG_DST_OFF:    prdata = {14'd0, dst_off_r};
      ptro_pkg::REG_DST_EN:     prdata = {31'd0, dst_en_r};
      ptro_pkg::REG_START_DATE: prdata = {11'd0, start_date_r};
      ptro_pkg::REG_START_TIME: prdata = {11'd0, start_time_r};
      ptro_pkg::REG_END_DATE:   prdata = {11'd0, end_date_r};
      ptro_pkg::REG_END_TIME:   prdata = {11'd0, end_time_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // global advance: everything moves unless a finished result is held
  logic out_valid_r;
  logic en;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // year search
  ptro_pkg::year_req_t search_in, search_out;

  assign search_in.valid = in_valid;
  assign search_in.secs  = in_unix_seconds;
  assign search_in.yoff  = '0;

  ptro_year_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .req_in  (search_in),
    .req_out (search_out)
  );

  // start is shifted by the standard offset, end by the daylight offset
  logic               rule_valid, end_valid;
  logic signed [39:0] start_utc, end_utc;

  ptro_rule_eval u_start (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (search_out.valid),
    .in_yoff   (search_out.yoff),
    .rule_date (start_date_r),
    .rule_time (start_time_r),
    .shift_off (std_off_r),
    .out_valid (rule_valid),
    .out_utc   (start_utc)
  );

  ptro_rule_eval u_end (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (search_out.valid),
    .in_yoff   (search_out.yoff),
    .rule_date (end_date_r),
    .rule_time (end_time_r),
    .shift_off (dst_off_r),
    .out_valid (end_valid),
    .out_utc   (end_utc)
  );

  // instant travels beside the rule stages
  localparam int RULE_DEPTH = 4;
  logic signed [34:0] secs_dly_r [0:RULE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      secs_dly_r[0] <= search_out.secs;
      for (int i = 1; i < RULE_DEPTH; i++) begin
        secs_dly_r[i] <= secs_dly_r[i-1];
      end
    end
  end

  // decision: northern window [start, end), southern wraps around the year
  logic signed [39:0] secs_x;
  logic               after_start, before_end, in_window;
  logic               use_dst;

  always_comb begin
    secs_x      = 40'(secs_dly_r[RULE_DEPTH-1]);
    after_start = secs_x >= start_utc;
    before_end  = secs_x < end_utc;
    if (start_utc <= end_utc) in_window = after_start && before_end;
    else in_window = after_start || before_end;
    use_dst = dst_en_r && in_window;
  end

  logic signed [17:0] out_off_r;
  logic               out_dst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rule_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_off_r <= use_dst ? dst_off_r : std_off_r;
      out_dst_r <= use_dst;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_utc_offset_seconds = out_off_r;
  assign out_in_dst             = out_dst_r;

  `ASSERT_NXT(a_out_load, clk, rst_n, en, out_valid_r == $past(rule_valid))
  `ASSERT_IMP(a_rules_aligned, clk, rst_n, 1'b1, rule_valid == end_valid)

endmodule

/* rtl/ptro_year_search.sv */
// ----------------------------------------------------------------------------
// ptro_year_search
// pipelined binary search for the utc year, one offset bit per stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptro_year_search (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ptro_pkg::year_req_t  req_in,
  output ptro_pkg::year_req_t  req_out
);

  localparam int STEPS = ptro_pkg::SEARCH_STEPS;

  logic                                valid_r [1:STEPS];
  logic signed [34:0]                  secs_r  [1:STEPS];
  logic [ptro_pkg::YOFF_W-1:0]         k_r     [1:STEPS];

  for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
    localparam logic [ptro_pkg::YOFF_W-1:0] BITV =
      ptro_pkg::YOFF_W'(1) << (STEPS - 1 - gi);
    logic                        src_v;
    logic signed [34:0]          src_s;
    logic [ptro_pkg::YOFF_W-1:0] src_k;
    logic [ptro_pkg::YOFF_W-1:0] cand;
    logic signed [17:0]          yd;
    logic signed [35:0]          ystart;
    logic                        take;

    if (gi == 0) begin : g_src_in
      assign src_v = req_in.valid;
      assign src_s = req_in.secs;
      assign src_k = '0;
    end else begin : g_src_reg
      assign src_v = valid_r[gi];
      assign src_s = secs_r[gi];
      assign src_k = k_r[gi];
    end

    // keep the bit when that year is within range and still starts at or before the instant
    always_comb begin
      cand   = src_k | BITV;
      yd     = ptro_pkg::year_days(ptro_pkg::YEAR_LOW + {3'd0, cand});
      ystart = 36'(yd) * 36'sd86400;
      take   = (cand <= ptro_pkg::YOFF_MAX) && (ystart <= 36'(src_s));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[gi+1] <= 1'b0;
      end else if (en) begin
        valid_r[gi+1] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        secs_r[gi+1] <= src_s;
        k_r[gi+1]    <= take ? cand : src_k;
      end
    end
  end

  assign req_out.valid = valid_r[STEPS];
  assign req_out.secs  = secs_r[STEPS];
  assign req_out.yoff  = k_r[STEPS];

  `ASSERT_IMP(a_yoff_range, clk, rst_n, valid_r[STEPS], k_r[STEPS] <= ptro_pkg::YOFF_MAX)

endmodule

/* rtl/ptro_rule_eval.sv */
// ----------------------------------------------------------------------------
// ptro_rule_eval
// four-stage evaluation of one packed rule to a utc instant for a year
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptro_rule_eval (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ptro_pkg::YOFF_W-1:0]  in_yoff,
  input  logic [20:0]                  rule_date,
  input  logic signed [20:0]           rule_time,
  input  logic signed [17:0]           shift_off,
  output logic                         out_valid,
  output logic signed [39:0]           out_utc
);

  // stage 1: year, leap, jan 1 and first of month
  logic [11:0]        yr;
  logic               leap;
  logic [3:0]         mon;
  logic [2:0]         wk;
  logic signed [17:0] jan1;
  logic signed [17:0] first_c;

  logic               v1_r;
  logic signed [17:0] jan1_r, first1_r;
  logic               leap_r;
  logic [4:0]         dim1_r;
  logic [1:0]         form1_r;
  logic [2:0]         wday1_r, wk1_r;
  logic [8:0]         yday_r;

  always_comb begin
    yr   = ptro_pkg::YEAR_LOW + {3'd0, in_yoff};
    leap = (yr[1:0] == 2'b00) && (yr != 12'd1900) && (yr != 12'd2100)
           && (yr != 12'd2200);
    if (rule_date[5:2] == 4'd0) mon = 4'd1;
    else if (rule_date[5:2] > 4'd12) mon = 4'd12;
    else mon = rule_date[5:2];
    wk      = (rule_date[8:6] > 3'd5) ? 3'd5 : rule_date[8:6];
    jan1    = ptro_pkg::year_days(yr);
    first_c = jan1 + $signed({9'd0, ptro_pkg::cum_days(mon)})
            + $signed({17'd0, (leap && mon > 4'd2)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jan1_r   <= jan1;
      first1_r <= first_c;
      leap_r   <= leap;
      dim1_r   <= ptro_pkg::month_len(mon, leap);
      form1_r  <= rule_date[1:0];
      wday1_r  <= rule_date[11:9];
      wk1_r    <= wk;
      yday_r   <= rule_date[20:12];
    end
  end

  // stage 2: reciprocal product for the weekday, day for the julian forms
  logic [16:0]        nv;
  logic [32:0]        prod_c;
  logic               jadj;
  logic signed [17:0] dayjn_c;

  logic               v2_r;
  logic [16:0]        nv_r;
  logic [32:0]        prod_r;
  logic signed [17:0] first2_r, dayjn_r;
  logic [4:0]         dim2_r;
  logic [1:0]         form2_r;
  logic [2:0]         wday2_r, wk2_r;

  always_comb begin
    nv      = 17'(first1_r + 18'sd28004);
    prod_c  = 33'(nv) * 33'd37449;
    jadj    = (yday_r > 9'd59) && leap_r;
    dayjn_c = jan1_r + $signed({9'd0, yday_r});
    if (form1_r == ptro_pkg::FORM_JDAY) begin
      dayjn_c = dayjn_c + $signed({17'd0, jadj}) - 18'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nv_r     <= nv;
      prod_r   <= prod_c;
      first2_r <= first1_r;
      dayjn_r  <= dayjn_c;
      dim2_r   <= dim1_r;
      form2_r  <= form1_r;
      wday2_r  <= wday1_r;
      wk2_r    <= wk1_r;
    end
  end

  // stage 3: weekday of the first, nth weekday, last-week fallback
  logic [16:0]        rem17;
  logic [3:0]         dow4;
  logic [2:0]         dow;
  logic [3:0]         t1, t2;
  logic [2:0]         delta;
  logic signed [6:0]  off;
  logic signed [17:0] day_c;

  logic               v3_r;
  logic signed [17:0] day_r;

  always_comb begin
    rem17 = nv_r - 17'({2'd0, prod_r[32:18]}) * 17'd7;
    dow4  = (rem17[3:0] >= 4'd7) ? rem17[3:0] - 4'd7 : rem17[3:0];
    dow   = dow4[2:0];
    t1    = {1'b0, wday2_r} + 4'd7 - {1'b0, dow};
    t2    = (t1 >= 4'd7) ? t1 - 4'd7 : t1;
    t2    = (t2 >= 4'd7) ? t2 - 4'd7 : t2;
    delta = t2[2:0];
    off   = $signed({4'd0, delta}) + ($signed({4'd0, wk2_r}) - 7'sd1) * 7'sd7;
    if (off > $signed({2'd0, dim2_r}) - 7'sd1) begin
      off = off - 7'sd7;
    end
    if (form2_r == ptro_pkg::FORM_MWD) day_c = first2_r + 18'(off);
    else day_c = dayjn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_r <= day_c;
    end
  end

  // stage 4: to seconds, local time of day, back to utc
  logic               v4_r;
  logic signed [39:0] utc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      utc_r <= 40'(day_r) * 40'sd86400 + 40'(rule_time) - 40'(shift_off);
    end
  end

  assign out_valid = v4_r;
  assign out_utc   = utc_r;

  `ASSERT_IMP(a_dow_range, clk, rst_n, v2_r, dow < 3'd7)

endmodule
